// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes and controller/datapath types of the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int NUM_BLOCKS_DEF = 64;

    localparam int CMD_W   = 2;
    localparam int SIZE_W  = 16;
    localparam int BIDX_W  = 6;
    localparam int STAT_W  = 3;
    localparam int FREE_W  = 7;
    localparam int CNT32_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RETURN_ALL = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_SIZE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATS_ENABLE = 1'd1;

    localparam logic [SIZE_W-1:0] BLOCK_BYTES_RST  = 16'd1024;
    localparam logic              STATS_ENABLE_RST = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the request and start its memory read
        logic scan_step;  // advance the return-all walk by one block
        logic commit;     // apply the operation and load the result register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;  // result register is empty or being drained
        logic scan_done;  // return-all walk has finished
    } t_ctl_stat;

endpackage

// ===== rtl/fbpa_req_if.sv =====
// ----------------------------------------------------------------------------
// fbpa_req_if
// Request channel of the block pool allocator.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
    logic                           valid;
    logic                           ready;
    logic [fbpa_pkg::CMD_W-1:0]     command;
    logic [fbpa_pkg::SIZE_W-1:0]    request_size;
    logic [fbpa_pkg::BIDX_W-1:0]    block_index;

    modport source (output valid, command, request_size, block_index, input ready);
    modport sink   (input valid, command, request_size, block_index, output ready);
endinterface

// ===== rtl/fbpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// Result channel of the block pool allocator.
// ----------------------------------------------------------------------------
interface fbpa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fbpa_pkg::STAT_W-1:0]    status;
    logic [fbpa_pkg::BIDX_W-1:0]    granted_index;
    logic [fbpa_pkg::FREE_W-1:0]    free_blocks;
    logic                           pool_exhausted;
    logic [fbpa_pkg::CNT32_W-1:0]   usage_bytes;
    logic [fbpa_pkg::CNT32_W-1:0]   peak_bytes;
    logic [fbpa_pkg::CNT32_W-1:0]   grant_total;
    logic [fbpa_pkg::CNT32_W-1:0]   release_total;

    modport source (output valid, status, granted_index, free_blocks, pool_exhausted,
                    usage_bytes, peak_bytes, grant_total, release_total, input ready);
    modport sink   (input valid, status, granted_index, free_blocks, pool_exhausted,
                    usage_bytes, peak_bytes, grant_total, release_total, output ready);
endinterface

// ===== rtl/fbpa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fbpa_cfg_if
// Register write channel of the block pool allocator.
// ----------------------------------------------------------------------------
interface fbpa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fbpa_pkg::CFG_IDX_W-1:0]     index;
    logic [fbpa_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer of the block pool allocator: accept, return-all walk, commit.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [fbpa_pkg::CMD_W-1:0]  i_in_command,
    output logic                        o_in_ready,
    output fbpa_pkg::t_ctl_cmd          o_cmd,
    input  fbpa_pkg::t_ctl_stat         i_stat
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_command == fbpa_pkg::CMD_RETURN_ALL) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // The operation is applied only once its result has a place to go.
                if (i_stat.slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/fbpa_dpath.sv =====
// ----------------------------------------------------------------------------
// fbpa_dpath
// Free list, taken bits, statistics and result register of the pool allocator.
// ----------------------------------------------------------------------------
module fbpa_dpath #(
    parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request payload, sampled on accept
    input  logic [fbpa_pkg::CMD_W-1:0]       i_command,
    input  logic [fbpa_pkg::SIZE_W-1:0]      i_request_size,
    input  logic [fbpa_pkg::BIDX_W-1:0]      i_block_index,
    // register writes
    input  logic                             i_cfg_valid,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // controller
    input  fbpa_pkg::t_ctl_cmd               i_cmd,
    output fbpa_pkg::t_ctl_stat              o_stat,
    // result
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [fbpa_pkg::STAT_W-1:0]      o_status,
    output logic [fbpa_pkg::BIDX_W-1:0]      o_granted_index,
    output logic [fbpa_pkg::FREE_W-1:0]      o_free_blocks,
    output logic                             o_pool_exhausted,
    output logic [fbpa_pkg::CNT32_W-1:0]     o_usage_bytes,
    output logic [fbpa_pkg::CNT32_W-1:0]     o_peak_bytes,
    output logic [fbpa_pkg::CNT32_W-1:0]     o_grant_total,
    output logic [fbpa_pkg::CNT32_W-1:0]     o_release_total
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int RAM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] NumBlocksC = CNT_W'(NUM_BLOCKS);

    // Memory word: {taken bit, link to next listed block}.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_rdata;
    logic             rd_taken;
    logic [CNT_W-1:0] rd_link;

    // Control state.
    logic [CNT_W-1:0] r_head,  n_head;
    logic [CNT_W-1:0] r_free,  n_free;
    logic [CNT_W-1:0] r_fill,  n_fill;
    logic [fbpa_pkg::CNT32_W-1:0] r_usage,    n_usage;
    logic [fbpa_pkg::CNT32_W-1:0] r_peak,     n_peak;
    logic [fbpa_pkg::CNT32_W-1:0] r_grants,   n_grants;
    logic [fbpa_pkg::CNT32_W-1:0] r_releases, n_releases;
    logic [fbpa_pkg::SIZE_W-1:0]  r_block_bytes;
    logic                         r_stats_en;
    logic [CNT_W-1:0] r_scan_rd, n_scan_rd;
    logic             r_scan_pend, n_scan_pend;
    logic             r_out_valid;

    // Payload.
    logic [fbpa_pkg::CMD_W-1:0]  r_cmd;
    logic [fbpa_pkg::SIZE_W-1:0] r_size;
    logic [fbpa_pkg::BIDX_W-1:0] r_bidx;
    logic [IDX_W-1:0]            r_scan_proc, n_scan_proc;
    logic [fbpa_pkg::STAT_W-1:0] r_out_status, n_status;
    logic [fbpa_pkg::BIDX_W-1:0] r_out_granted, n_granted;
    logic [fbpa_pkg::FREE_W-1:0] r_out_free;
    logic                        r_out_exh;
    logic [fbpa_pkg::CNT32_W-1:0] r_out_usage, r_out_peak, r_out_grants, r_out_releases;

    // Helpers.
    logic [IDX_W-1:0]             head_idx;
    logic                         head_filled;
    logic [CNT_W-1:0]             pop_link;
    logic [IDX_W-1:0]             free_addr;
    logic                         free_ok;
    logic                         scan_more;
    logic [fbpa_pkg::CNT32_W:0]   usage_sum;
    logic [fbpa_pkg::CNT32_W-1:0] block_bytes_ext;

    fbpa_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_taken = ram_rdata[CNT_W];
    assign rd_link  = ram_rdata[CNT_W-1:0];

    // Blocks at or above the fill mark were never handed out, so their memory
    // entries were never written: they read as not taken, linking to the next
    // index.
    assign head_idx    = r_head[IDX_W-1:0];
    assign head_filled = r_head < r_fill;
    assign pop_link    = head_filled ? rd_link : r_head + CNT_W'(1);
    assign free_addr   = IDX_W'(r_bidx);
    assign free_ok     = (32'(r_bidx) < 32'(NUM_BLOCKS)) &&
                         ({1'b0, free_addr} < r_fill) && rd_taken;
    assign scan_more   = r_scan_rd < r_fill;

    assign usage_sum       = {1'b0, r_usage} + {17'd0, r_size};
    assign block_bytes_ext = {16'd0, r_block_bytes};

    // Read port: the request's own entry on accept, else the walk pointer.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_scan_rd[IDX_W-1:0];
        if (i_cmd.accept) begin
            ram_re = 1'b1;
            if (i_command == fbpa_pkg::CMD_ALLOC) begin
                ram_raddr = head_idx;
            end else begin
                ram_raddr = IDX_W'(i_block_index);
            end
        end else if (i_cmd.scan_step) begin
            ram_re = scan_more;
        end
    end

    always_comb begin
        n_head      = r_head;
        n_free      = r_free;
        n_fill      = r_fill;
        n_usage     = r_usage;
        n_peak      = r_peak;
        n_grants    = r_grants;
        n_releases  = r_releases;
        n_scan_rd   = r_scan_rd;
        n_scan_pend = r_scan_pend;
        n_scan_proc = r_scan_proc;
        n_status    = fbpa_pkg::ST_OK;
        n_granted   = '0;
        ram_we      = 1'b0;
        ram_waddr   = head_idx;
        ram_wdata   = '0;

        if (i_cmd.accept) begin
            n_scan_rd   = '0;
            n_scan_pend = 1'b0;
        end

        if (i_cmd.scan_step) begin
            if (scan_more) begin
                n_scan_rd   = r_scan_rd + CNT_W'(1);
                n_scan_pend = 1'b1;
                n_scan_proc = r_scan_rd[IDX_W-1:0];
            end else begin
                n_scan_pend = 1'b0;
            end
            // Data for the previous walk index is in the read register now.
            if (r_scan_pend && rd_taken) begin
                ram_we    = 1'b1;
                ram_waddr = r_scan_proc;
                ram_wdata = {1'b0, r_head};
                n_head    = CNT_W'(r_scan_proc);
                n_free    = r_free + CNT_W'(1);
            end
        end

        if (i_cmd.commit) begin
            case (r_cmd)
                fbpa_pkg::CMD_ALLOC: begin
                    if (r_size == '0) begin
                        n_status = fbpa_pkg::ST_ZERO_SIZE;
                    end else if (r_size > r_block_bytes) begin
                        n_status = fbpa_pkg::ST_TOO_LARGE;
                    end else if (r_free == '0) begin
                        n_status = fbpa_pkg::ST_EXHAUSTED;
                    end else begin
                        n_granted = fbpa_pkg::BIDX_W'(head_idx);
                        ram_we    = 1'b1;
                        ram_waddr = head_idx;
                        ram_wdata = {1'b1, pop_link};
                        n_head    = pop_link;
                        n_free    = r_free - CNT_W'(1);
                        if (!head_filled) begin
                            n_fill = r_head + CNT_W'(1);
                        end
                        if (r_stats_en) begin
                            n_usage  = usage_sum[fbpa_pkg::CNT32_W] ? '1 :
                                       usage_sum[fbpa_pkg::CNT32_W-1:0];
                            n_peak   = (n_usage > r_peak) ? n_usage : r_peak;
                            n_grants = r_grants + 32'd1;
                        end
                    end
                end
                fbpa_pkg::CMD_FREE: begin
                    if (!free_ok) begin
                        n_status = fbpa_pkg::ST_DOUBLE_FREE;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = free_addr;
                        ram_wdata = {1'b0, r_head};
                        n_head    = CNT_W'(free_addr);
                        n_free    = r_free + CNT_W'(1);
                        if (r_stats_en) begin
                            n_usage    = (r_usage > block_bytes_ext) ?
                                         r_usage - block_bytes_ext : '0;
                            n_releases = r_releases + 32'd1;
                        end
                    end
                end
                fbpa_pkg::CMD_RETURN_ALL: begin
                    // The walk has already relinked the blocks.
                    n_usage    = '0;
                    n_grants   = '0;
                    n_releases = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_free        <= NumBlocksC;
            r_fill        <= '0;
            r_usage       <= '0;
            r_peak        <= '0;
            r_grants      <= '0;
            r_releases    <= '0;
            r_block_bytes <= fbpa_pkg::BLOCK_BYTES_RST;
            r_stats_en    <= fbpa_pkg::STATS_ENABLE_RST;
            r_scan_rd     <= '0;
            r_scan_pend   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_free      <= n_free;
            r_fill      <= n_fill;
            r_usage     <= n_usage;
            r_peak      <= n_peak;
            r_grants    <= n_grants;
            r_releases  <= n_releases;
            r_scan_rd   <= n_scan_rd;
            r_scan_pend <= n_scan_pend;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fbpa_pkg::CFG_BLOCK_BYTES:  r_block_bytes <= i_cfg_data;
                    fbpa_pkg::CFG_STATS_ENABLE: r_stats_en    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_proc <= n_scan_proc;
        if (i_cmd.accept) begin
            r_cmd  <= i_command;
            r_size <= i_request_size;
            r_bidx <= i_block_index;
        end
        if (i_cmd.commit) begin
            r_out_status   <= n_status;
            r_out_granted  <= n_granted;
            r_out_free     <= fbpa_pkg::FREE_W'(n_free);
            r_out_exh      <= (n_free == '0);
            r_out_usage    <= n_usage;
            r_out_peak     <= n_peak;
            r_out_grants   <= n_grants;
            r_out_releases <= n_releases;
        end
    end

    assign o_stat.slot_free = !r_out_valid || i_out_ready;
    assign o_stat.scan_done = !scan_more && !r_scan_pend;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_granted_index  = r_out_granted;
    assign o_free_blocks    = r_out_free;
    assign o_pool_exhausted = r_out_exh;
    assign o_usage_bytes    = r_out_usage;
    assign o_peak_bytes     = r_out_peak;
    assign o_grant_total    = r_out_grants;
    assign o_release_total  = r_out_releases;

`ifndef SYNTH
    // Every block at or above the fill mark is still on the list.
    a_free_covers_unfilled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free >= NumBlocksC - r_fill)
        else $error("free count below the number of never-used blocks");

    // A nonempty list always has a real block at its head.
    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free != '0) |-> (r_head < NumBlocksC))
        else $error("list head out of range while list is nonempty");

    // The walk only inspects blocks below the fill mark.
    a_scan_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_pend |-> ({1'b0, r_scan_proc} < r_fill))
        else $error("return-all walk beyond the fill mark");

    // A committed operation always presents a result.
    a_commit_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit without a result");
`endif

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal blocks kept on a LIFO free list, with usage statistics.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  i_req     in   command, request_size, block_index
//  o_rsp     out  status, granted_index, free_blocks, pool_exhausted,
//                 usage_bytes, peak_bytes, grant_total, release_total
//  i_cfg     in   index (0 block_bytes, 1 stats_enable), data
//
// Allocate, free and the unused command read the link memory in the transfer
// cycle, then update it and load the result register once that register is free.
// Return-all walks the F distinct blocks ever handed out since reset: the walk
// reads one link memory entry a cycle, then handles the last entry and finishes.
// Reset is synchronous and immediate; a fill mark stands in for clearing the
// link memory. A new request is taken while a result waits; its own result
// waits in turn until the result register is drained.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
    parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fbpa_req_if.sink      i_req,
    fbpa_rsp_if.source    o_rsp,
    fbpa_cfg_if.sink      i_cfg
);

    fbpa_pkg::t_ctl_cmd  ctl_cmd;
    fbpa_pkg::t_ctl_stat ctl_stat;
    logic                in_ready;

    fbpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .i_in_command (i_req.command),
        .o_in_ready   (in_ready),
        .o_cmd        (ctl_cmd),
        .i_stat       (ctl_stat)
    );

    fbpa_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_command        (i_req.command),
        .i_request_size   (i_req.request_size),
        .i_block_index    (i_req.block_index),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_cmd            (ctl_cmd),
        .o_stat           (ctl_stat),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_granted_index  (o_rsp.granted_index),
        .o_free_blocks    (o_rsp.free_blocks),
        .o_pool_exhausted (o_rsp.pool_exhausted),
        .o_usage_bytes    (o_rsp.usage_bytes),
        .o_peak_bytes     (o_rsp.peak_bytes),
        .o_grant_total    (o_rsp.grant_total),
        .o_release_total  (o_rsp.release_total)
    );

    assign i_req.ready = in_ready;
    // Register writes are always taken.
    assign i_cfg.ready = 1'b1;

endmodule

// ===== sim/fixed_block_pool_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Drives allocate, free and return-all requests into the block pool allocator
// under random source and sink idling. Each result is checked field by field
// against a free-list predictor kept in the testbench. A directed table comes
// first, then random phases under several block size and statistics settings.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_tb;

    localparam int NB            = fbpa_pkg::NUM_BLOCKS_DEF;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 105;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    // The fourth command encoding has no operation assigned.
    localparam logic [fbpa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [fbpa_pkg::STAT_W-1:0]  status;
        logic [fbpa_pkg::BIDX_W-1:0]  granted_index;
        logic [fbpa_pkg::FREE_W-1:0]  free_blocks;
        logic                         pool_exhausted;
        logic [fbpa_pkg::CNT32_W-1:0] usage_bytes;
        logic [fbpa_pkg::CNT32_W-1:0] peak_bytes;
        logic [fbpa_pkg::CNT32_W-1:0] grant_total;
        logic [fbpa_pkg::CNT32_W-1:0] release_total;
    } t_pool_result;

    // A request, plus the fields of its result that are pinned by hand.
    typedef struct packed {
        logic [fbpa_pkg::CMD_W-1:0]   command;
        logic [fbpa_pkg::SIZE_W-1:0]  request_size;
        logic [fbpa_pkg::BIDX_W-1:0]  block_index;
        logic                         pinned;
        logic [fbpa_pkg::STAT_W-1:0]  status;
        logic [fbpa_pkg::BIDX_W-1:0]  granted_index;
        logic [fbpa_pkg::FREE_W-1:0]  free_blocks;
    } t_plan_row;

    localparam int PLAN_ROWS = 19;

    // Runs with block_bytes 1024 and statistics enabled, straight after reset.
    t_plan_row directed_plan [PLAN_ROWS] = '{
        '{fbpa_pkg::CMD_ALLOC, 16'd0, 6'd0, 1'b1, fbpa_pkg::ST_ZERO_SIZE, 6'd0, 7'd64},
        '{fbpa_pkg::CMD_ALLOC, 16'd1025, 6'd0, 1'b1, fbpa_pkg::ST_TOO_LARGE, 6'd0, 7'd64},
        '{fbpa_pkg::CMD_ALLOC, 16'hFFFF, 6'd63, 1'b1, fbpa_pkg::ST_TOO_LARGE, 6'd0, 7'd64},
        '{fbpa_pkg::CMD_FREE, 16'd0, 6'd0, 1'b1, fbpa_pkg::ST_DOUBLE_FREE, 6'd0, 7'd64},
        '{fbpa_pkg::CMD_FREE, 16'hFFFF, 6'd63, 1'b1, fbpa_pkg::ST_DOUBLE_FREE, 6'd0, 7'd64},
        '{CMD_UNUSED, 16'hFFFF, 6'd63, 1'b1, fbpa_pkg::ST_OK, 6'd0, 7'd64},
        '{fbpa_pkg::CMD_RETURN_ALL, 16'd0, 6'd0, 1'b1, fbpa_pkg::ST_OK, 6'd0, 7'd64},
        '{fbpa_pkg::CMD_ALLOC, 16'd1, 6'd0, 1'b1, fbpa_pkg::ST_OK, 6'd0, 7'd63},
        '{fbpa_pkg::CMD_ALLOC, 16'd1024, 6'd63, 1'b1, fbpa_pkg::ST_OK, 6'd1, 7'd62},
        '{fbpa_pkg::CMD_ALLOC, 16'd512, 6'd0, 1'b1, fbpa_pkg::ST_OK, 6'd2, 7'd61},
        '{fbpa_pkg::CMD_FREE, 16'd0, 6'd1, 1'b1, fbpa_pkg::ST_OK, 6'd0, 7'd62},
        '{fbpa_pkg::CMD_FREE, 16'd0, 6'd1, 1'b1, fbpa_pkg::ST_DOUBLE_FREE, 6'd0, 7'd62},
        '{fbpa_pkg::CMD_ALLOC, 16'd7, 6'd0, 1'b1, fbpa_pkg::ST_OK, 6'd1, 7'd61},
        '{fbpa_pkg::CMD_FREE, 16'd0, 6'd63, 1'b1, fbpa_pkg::ST_DOUBLE_FREE, 6'd0, 7'd61},
        // Usage is below one block here, so this free clamps it at zero.
        '{fbpa_pkg::CMD_FREE, 16'd0, 6'd0, 1'b1, fbpa_pkg::ST_OK, 6'd0, 7'd62},
        '{fbpa_pkg::CMD_RETURN_ALL, 16'hFFFF, 6'd63, 1'b1, fbpa_pkg::ST_OK, 6'd0, 7'd64},
        '{fbpa_pkg::CMD_ALLOC, 16'd1, 6'd0, 1'b0, fbpa_pkg::ST_OK, 6'd0, 7'd0},
        '{fbpa_pkg::CMD_ALLOC, 16'd1023, 6'd0, 1'b0, fbpa_pkg::ST_OK, 6'd0, 7'd0},
        '{CMD_UNUSED, 16'd0, 6'd0, 1'b0, fbpa_pkg::ST_OK, 6'd0, 7'd0}
    };

    logic [fbpa_pkg::SIZE_W-1:0] phase_bytes [PHASES] =
        '{16'hFFFF, 16'd1, 16'd0, 16'd300, 16'd0, 16'd1024};
    logic phase_stats [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    logic i_clk = 1'b0;
    logic i_rst_n;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();
    fbpa_cfg_if cfg_ch ();

    fixed_block_pool_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state of the pool.
    logic [6:0]                   link_of [NB];
    logic [6:0]                   top_of_list;
    logic [NB-1:0]                held;
    logic [fbpa_pkg::FREE_W-1:0]  spare_count;
    logic [fbpa_pkg::CNT32_W-1:0] bytes_in_use;
    logic [fbpa_pkg::CNT32_W-1:0] bytes_peak;
    logic [fbpa_pkg::CNT32_W-1:0] grant_count;
    logic [fbpa_pkg::CNT32_W-1:0] release_count;
    logic [fbpa_pkg::SIZE_W-1:0]  cfg_block_bytes;
    logic                         cfg_stats_on;

    t_pool_result awaited_results [$];
    int  fail_count  = 0;
    int  idle_cycles = 0;
    bit  no_idle     = 1'b0;
    bit  filling     = 1'b1;

    function automatic void reset_pool_model();
        for (int b = 0; b < NB; b++)
            link_of[b] = 7'(b + 1);
        top_of_list     = '0;
        held            = '0;
        spare_count     = 7'(NB);
        bytes_in_use    = '0;
        bytes_peak      = '0;
        grant_count     = '0;
        release_count   = '0;
        cfg_block_bytes = fbpa_pkg::BLOCK_BYTES_RST;
        cfg_stats_on    = fbpa_pkg::STATS_ENABLE_RST;
    endfunction

    function automatic void return_block(int unsigned b);
        link_of[b]  = top_of_list;
        top_of_list = 7'(b);
        held[b]     = 1'b0;
        spare_count = spare_count + 7'd1;
    endfunction

    function automatic t_pool_result apply_pool_command(t_plan_row row);
        t_pool_result res;
        logic [32:0]  sum;
        res = '0;
        res.status = fbpa_pkg::ST_OK;
        case (row.command)
            fbpa_pkg::CMD_ALLOC: begin
                if (row.request_size == '0) begin
                    res.status = fbpa_pkg::ST_ZERO_SIZE;
                end else if (row.request_size > cfg_block_bytes) begin
                    res.status = fbpa_pkg::ST_TOO_LARGE;
                end else if (spare_count == '0 || top_of_list >= 7'(NB)) begin
                    res.status = fbpa_pkg::ST_EXHAUSTED;
                end else begin
                    res.granted_index = top_of_list[fbpa_pkg::BIDX_W-1:0];
                    top_of_list = link_of[res.granted_index];
                    held[res.granted_index] = 1'b1;
                    spare_count = spare_count - 7'd1;
                    if (cfg_stats_on) begin
                        sum = {1'b0, bytes_in_use} + {17'd0, row.request_size};
                        bytes_in_use = sum[32] ? '1 : sum[31:0];
                        if (bytes_in_use > bytes_peak)
                            bytes_peak = bytes_in_use;
                        grant_count = grant_count + 32'd1;
                    end
                end
            end
            fbpa_pkg::CMD_FREE: begin
                if (!held[row.block_index]) begin
                    res.status = fbpa_pkg::ST_DOUBLE_FREE;
                end else begin
                    if (cfg_stats_on) begin
                        bytes_in_use = (bytes_in_use > {16'd0, cfg_block_bytes}) ?
                                       bytes_in_use - {16'd0, cfg_block_bytes} : '0;
                        release_count = release_count + 32'd1;
                    end
                    return_block(row.block_index);
                end
            end
            fbpa_pkg::CMD_RETURN_ALL: begin
                for (int b = 0; b < NB; b++)
                    if (held[b])
                        return_block(b);
                bytes_in_use  = '0;
                grant_count   = '0;
                release_count = '0;
            end
            default: ;
        endcase
        res.free_blocks    = spare_count;
        res.pool_exhausted = (spare_count == '0);
        res.usage_bytes    = bytes_in_use;
        res.peak_bytes     = bytes_peak;
        res.grant_total    = grant_count;
        res.release_total  = release_count;
        if (row.pinned) begin
            res.status        = row.status;
            res.granted_index = row.granted_index;
            res.free_blocks   = row.free_blocks;
        end
        return res;
    endfunction

    // Mostly well-formed traffic that follows the pool contents, with some noise.
    function automatic t_plan_row pick_random_request();
        t_plan_row   row;
        logic [31:0] draw;
        int unsigned roll;
        int unsigned start;
        int unsigned slot;
        bit          found;
        row   = '0;
        found = 1'b0;
        draw  = $urandom;
        row.request_size = draw[fbpa_pkg::SIZE_W-1:0];
        row.block_index  = draw[21:16];
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            row.command = fbpa_pkg::CMD_RETURN_ALL;
        end else if (roll < 7) begin
            row.command = CMD_UNUSED;
        end else if (roll < 12) begin
            row.command = fbpa_pkg::CMD_FREE;
        end else if (roll < 17) begin
            row.command = fbpa_pkg::CMD_ALLOC;
        end else if (filling || held == '0) begin
            row.command = fbpa_pkg::CMD_ALLOC;
            if (cfg_block_bytes != '0) begin
                roll = $urandom_range(0, 7);
                if (roll == 0)
                    row.request_size = cfg_block_bytes;
                else if (roll == 1)
                    row.request_size = 16'd1;
                else
                    row.request_size =
                        fbpa_pkg::SIZE_W'($urandom_range(1, cfg_block_bytes));
            end
        end else begin
            row.command = fbpa_pkg::CMD_FREE;
            start = $urandom_range(0, NB - 1);
            for (int k = 0; k < NB; k++) begin
                slot = (start + k) % NB;
                if (!found && held[slot]) begin
                    row.block_index = fbpa_pkg::BIDX_W'(slot);
                    found = 1'b1;
                end
            end
        end
        return row;
    endfunction

    task automatic issue_request(input t_plan_row row);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= row.command;
        req_ch.request_size <= row.request_size;
        req_ch.block_index  <= row.block_index;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        awaited_results.push_back(apply_pool_command(row));
    endtask

    // Holds the request side until every outstanding result has been drained.
    task automatic drain_pool();
        req_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_register(input logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [fbpa_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        if (idx == fbpa_pkg::CFG_BLOCK_BYTES)
            cfg_block_bytes = value;
        else
            cfg_stats_on = value[0];
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    initial begin : stimulus
        logic [31:0] draw;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= fbpa_pkg::CMD_ALLOC;
        req_ch.request_size <= '0;
        req_ch.block_index  <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= fbpa_pkg::CFG_BLOCK_BYTES;
        cfg_ch.data         <= '0;
        reset_pool_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k])
            issue_request(directed_plan[k]);

        for (int p = 0; p < PHASES; p++) begin
            drain_pool();
            draw = $urandom;
            write_register(fbpa_pkg::CFG_BLOCK_BYTES,
                           (p == 4) ? draw[15:0] : phase_bytes[p]);
            write_register(fbpa_pkg::CFG_STATS_ENABLE, {draw[31:17], phase_stats[p]});
            cfg_ch.valid <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    no_idle = ($urandom_range(0, 2) == 0);
                if (p == 1 && n == 50)
                    drain_pool();
                issue_request(pick_random_request());
                // Swing between filling the pool up and emptying it out.
                if (spare_count == '0 && $urandom_range(0, 3) == 0)
                    filling = 1'b0;
                if (held == '0 || $urandom_range(0, 49) == 0)
                    filling = ~filling | (held == '0);
            end
        end

        drain_pool();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : result_sink
        t_pool_result want;
        int unsigned  stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid)
                @(posedge i_clk);
            if (awaited_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected, status %0h",
                         $time, rsp_ch.status);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status",         want.status,         rsp_ch.status);
                check_field("granted_index",  want.granted_index,  rsp_ch.granted_index);
                check_field("free_blocks",    want.free_blocks,    rsp_ch.free_blocks);
                check_field("pool_exhausted", want.pool_exhausted, rsp_ch.pool_exhausted);
                check_field("usage_bytes",    want.usage_bytes,    rsp_ch.usage_bytes);
                check_field("peak_bytes",     want.peak_bytes,     rsp_ch.peak_bytes);
                check_field("grant_total",    want.grant_total,    rsp_ch.grant_total);
                check_field("release_total",  want.release_total,  rsp_ch.release_total);
            end
        end
    end

    // Ends a hung run: counts cycles without a transfer on any channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
